@@ src/cchit_pkg.sv @@
// Shared constants for the capsule and circle hit test core.
`default_nettype none

package cchit_pkg;

   // radius field width and the width of the sum of two radii
   localparam int RADIUS_WIDTH = 12;
   localparam int RSUM_WIDTH   = RADIUS_WIDTH + 1;

   // request tdata holds six coordinates and two radii, padded to bytes
   function automatic int req_data_width(input int coord_width);
      return ((6 * coord_width + 2 * RADIUS_WIDTH + 7) / 8) * 8;
   endfunction

   // result tdata holds the hit flag and two coordinates, padded to bytes
   function automatic int rsp_data_width(input int coord_width);
      return ((2 * coord_width + 1 + 7) / 8) * 8;
   endfunction

endpackage

`default_nettype wire

@@ src/capsule_circle_hit_test_core.sv @@
// Pipelined capsule versus circle hit test with closest point output.
//
// Usage:
//   A request transfer on the req_ channel carries both end points of the
//   capsule core segment, the circle centre, the two radii and a start select
//   bit in req_tuser. For each request exactly one result transfer appears on
//   the rsp_ channel with the hit flag and the closest point on the segment.
//   The centre is projected onto the segment, the ratio is clamped to [0, 1]
//   and the closest point is rounded half up; a zero-length segment yields
//   the start point.
//   A request passes stages 1 to 3, the divider setup and chain, then stages
//   4 to 8 to the result. Throughput is one item per cycle while the receiver
//   does not stall: the divider is a chain of T_FRAC_BITS restoring stages,
//   one quotient bit each, and every multiply has its own register stage.
//   Reset clears all stage valid bits; the pipeline then holds no items.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and req_tready drops; nothing is lost or repeated, and bubbles move on
//   whenever the output register is empty or being taken.
`default_nettype none

module capsule_circle_hit_test_core #(
   parameter int COORD_WIDTH = 16,
   parameter int T_FRAC_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   // end_a_x, end_a_y, end_b_x, end_b_y, center_x, center_y,
   // capsule_radius, circle_radius, zero pad
   input  wire logic [cchit_pkg::req_data_width(COORD_WIDTH)-1:0] req_tdata,
   // start_select
   input  wire logic                                              req_tuser,
   input  wire logic                                              req_tvalid,
   output      logic                                              req_tready,
   // hit, closest_x, closest_y, zero pad
   output      logic [cchit_pkg::rsp_data_width(COORD_WIDTH)-1:0] rsp_tdata,
   output      logic                                              rsp_tvalid,
   input  wire logic                                              rsp_tready
);
   import cchit_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int TF     = T_FRAC_BITS;
   localparam int TW     = TF + 1;
   localparam int GW     = CW + 1;
   localparam int PW     = 2 * GW;
   localparam int SW     = PW + 1;
   localparam int UW     = SW - 1;
   localparam int MW     = GW + TW + 1;
   localparam int QW     = 2 * RSUM_WIDTH;
   localparam int HW     = UW + QW;
   localparam int REQ_W  = req_data_width(CW);
   localparam int RSP_W  = rsp_data_width(CW);

   typedef struct packed {
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic signed [GW-1:0] gx;
      logic signed [GW-1:0] gy;
      logic [QW-1:0]        rsq;
   } carry_type;

   typedef struct packed {
      carry_type      c;
      logic [UW-1:0]  rem;
      logic [UW-1:0]  den;
      logic [TF-1:0]  quo;
      logic           fixed;
      logic [TW-1:0]  t_fix;
   } div_type;

   logic adv;

   // stage 1: select start, form differences
   logic                  s1_vld_ff;
   logic signed [CW-1:0]  s1_sx_ff, s1_sy_ff, s1_cx_ff, s1_cy_ff;
   logic signed [GW-1:0]  s1_gx_ff, s1_gy_ff, s1_vx_ff, s1_vy_ff;
   logic [RSUM_WIDTH-1:0] s1_rsum_ff;

   // stage 2: products
   logic                  s2_vld_ff;
   carry_type             s2_c_ff;
   logic signed [PW-1:0]  s2_da_ff, s2_db_ff, s2_la_ff, s2_lb_ff;

   // stage 3: dot and squared length
   logic                  s3_vld_ff;
   carry_type             s3_c_ff;
   logic signed [SW-1:0]  s3_dot_ff, s3_len_ff;

   // divider chain
   logic    div_vld_ff [0:TF];
   div_type div_ff     [0:TF];

   // stage 4: scale products
   logic                  s4_vld_ff;
   carry_type             s4_c_ff;
   logic signed [MW-1:0]  s4_mx_ff, s4_my_ff;

   // stage 5: closest point
   logic                  s5_vld_ff;
   carry_type             s5_c_ff;
   logic signed [CW-1:0]  s5_px_ff, s5_py_ff;

   // stage 6: offsets to centre
   logic                  s6_vld_ff;
   logic [QW-1:0]         s6_rsq_ff;
   logic signed [CW-1:0]  s6_px_ff, s6_py_ff;
   logic signed [GW-1:0]  s6_dx_ff, s6_dy_ff;

   // stage 7: squared offsets
   logic                  s7_vld_ff;
   logic [QW-1:0]         s7_rsq_ff;
   logic signed [CW-1:0]  s7_px_ff, s7_py_ff;
   logic signed [PW-1:0]  s7_qx_ff, s7_qy_ff;

   // stage 8: output register
   logic                  s8_vld_ff;
   logic                  s8_hit_ff;
   logic signed [CW-1:0]  s8_px_ff, s8_py_ff;

   // advance every stage when the output register is free or being taken
   assign adv        = rsp_tready || !s8_vld_ff;
   assign req_tready = adv;

   // unpack request fields
   logic signed [CW-1:0]    in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
   logic [RADIUS_WIDTH-1:0] in_rcap, in_rcir;
   logic signed [CW-1:0]    in_sx, in_sy, in_ex, in_ey;

   assign in_ax   = req_tdata[0*CW +: CW];
   assign in_ay   = req_tdata[1*CW +: CW];
   assign in_bx   = req_tdata[2*CW +: CW];
   assign in_by   = req_tdata[3*CW +: CW];
   assign in_cx   = req_tdata[4*CW +: CW];
   assign in_cy   = req_tdata[5*CW +: CW];
   assign in_rcap = req_tdata[6*CW +: RADIUS_WIDTH];
   assign in_rcir = req_tdata[6*CW + RADIUS_WIDTH +: RADIUS_WIDTH];
   assign in_sx   = req_tuser ? in_bx : in_ax;
   assign in_sy   = req_tuser ? in_by : in_ay;
   assign in_ex   = req_tuser ? in_ax : in_bx;
   assign in_ey   = req_tuser ? in_ay : in_by;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_tvalid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= div_vld_ff[TF];
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
         s8_vld_ff <= s7_vld_ff;
      end
   end

   // payload of the front stages
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sx_ff   <= in_sx;
         s1_sy_ff   <= in_sy;
         s1_cx_ff   <= in_cx;
         s1_cy_ff   <= in_cy;
         s1_gx_ff   <= GW'(in_ex) - GW'(in_sx);
         s1_gy_ff   <= GW'(in_ey) - GW'(in_sy);
         s1_vx_ff   <= GW'(in_cx) - GW'(in_sx);
         s1_vy_ff   <= GW'(in_cy) - GW'(in_sy);
         s1_rsum_ff <= RSUM_WIDTH'(in_rcap) + RSUM_WIDTH'(in_rcir);

         s2_c_ff.sx  <= s1_sx_ff;
         s2_c_ff.sy  <= s1_sy_ff;
         s2_c_ff.cx  <= s1_cx_ff;
         s2_c_ff.cy  <= s1_cy_ff;
         s2_c_ff.gx  <= s1_gx_ff;
         s2_c_ff.gy  <= s1_gy_ff;
         s2_c_ff.rsq <= QW'(s1_rsum_ff) * QW'(s1_rsum_ff);
         s2_da_ff    <= PW'(s1_vx_ff) * PW'(s1_gx_ff);
         s2_db_ff    <= PW'(s1_vy_ff) * PW'(s1_gy_ff);
         s2_la_ff    <= PW'(s1_gx_ff) * PW'(s1_gx_ff);
         s2_lb_ff    <= PW'(s1_gy_ff) * PW'(s1_gy_ff);

         s3_c_ff   <= s2_c_ff;
         s3_dot_ff <= SW'(s2_da_ff) + SW'(s2_db_ff);
         s3_len_ff <= SW'(s2_la_ff) + SW'(s2_lb_ff);
      end
   end

   // divider setup: settle the clamped cases, load the remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         div_vld_ff[0] <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0].c   <= s3_c_ff;
         div_ff[0].rem <= s3_dot_ff[UW-1:0];
         div_ff[0].den <= s3_len_ff[UW-1:0];
         div_ff[0].quo <= '0;
         if (s3_dot_ff <= 0 || s3_len_ff <= 0) begin
            div_ff[0].fixed <= 1'b1;
            div_ff[0].t_fix <= '0;
         end else if (s3_dot_ff >= s3_len_ff) begin
            div_ff[0].fixed <= 1'b1;
            div_ff[0].t_fix <= TW'(1) << TF;
         end else begin
            div_ff[0].fixed <= 1'b0;
            div_ff[0].t_fix <= '0;
         end
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar k = 1; k <= TF; k++) begin : g_div
      logic [UW:0] rem2;
      logic [UW:0] diff;
      logic        take;

      always_comb begin
         rem2 = {div_ff[k-1].rem, 1'b0};
         diff = rem2 - {1'b0, div_ff[k-1].den};
         take = rem2 >= {1'b0, div_ff[k-1].den};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            div_vld_ff[k] <= div_vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k].c     <= div_ff[k-1].c;
            div_ff[k].den   <= div_ff[k-1].den;
            div_ff[k].fixed <= div_ff[k-1].fixed;
            div_ff[k].t_fix <= div_ff[k-1].t_fix;
            div_ff[k].rem   <= take ? diff[UW-1:0] : rem2[UW-1:0];
            div_ff[k].quo   <= {div_ff[k-1].quo[TF-2:0], take};
         end
      end
   end

   // pick the ratio and scale both segment components
   logic [TW-1:0]        t_sel;
   logic signed [MW-1:0] t_ext;

   assign t_sel = div_ff[TF].fixed ? div_ff[TF].t_fix : {1'b0, div_ff[TF].quo};
   assign t_ext = $signed(MW'(t_sel));

   // round half up, add start, then the rest of the back end
   logic signed [MW-1:0] rx, ry;

   assign rx = (s4_mx_ff + (MW'(1) <<< (TF - 1))) >>> TF;
   assign ry = (s4_my_ff + (MW'(1) <<< (TF - 1))) >>> TF;

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_c_ff  <= div_ff[TF].c;
         s4_mx_ff <= MW'(div_ff[TF].c.gx) * t_ext;
         s4_my_ff <= MW'(div_ff[TF].c.gy) * t_ext;

         s5_c_ff  <= s4_c_ff;
         s5_px_ff <= CW'(GW'(s4_c_ff.sx) + rx[GW-1:0]);
         s5_py_ff <= CW'(GW'(s4_c_ff.sy) + ry[GW-1:0]);

         s6_rsq_ff <= s5_c_ff.rsq;
         s6_px_ff  <= s5_px_ff;
         s6_py_ff  <= s5_py_ff;
         s6_dx_ff  <= GW'(s5_c_ff.cx) - GW'(s5_px_ff);
         s6_dy_ff  <= GW'(s5_c_ff.cy) - GW'(s5_py_ff);

         s7_rsq_ff <= s6_rsq_ff;
         s7_px_ff  <= s6_px_ff;
         s7_py_ff  <= s6_py_ff;
         s7_qx_ff  <= PW'(s6_dx_ff) * PW'(s6_dx_ff);
         s7_qy_ff  <= PW'(s6_dy_ff) * PW'(s6_dy_ff);

         s8_px_ff  <= s7_px_ff;
         s8_py_ff  <= s7_py_ff;
         s8_hit_ff <= HW'(UW'(SW'(s7_qx_ff) + SW'(s7_qy_ff))) <= HW'(s7_rsq_ff);
      end
   end

   // drive the result channel
   assign rsp_tvalid = s8_vld_ff;
   assign rsp_tdata  = RSP_W'({s8_py_ff, s8_px_ff, s8_hit_ff});

endmodule

`default_nettype wire

@@ src/capsule_circle_hit_test_checker.sv @@
// Port checker for the capsule and circle hit test core, with its bind.
`default_nettype none

module capsule_circle_hit_test_checker #(
   parameter int COORD_WIDTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic [cchit_pkg::rsp_data_width(COORD_WIDTH)-1:0] rsp_tdata,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready
);
   import cchit_pkg::*;

   localparam int RSP_W = rsp_data_width(COORD_WIDTH);

   // the pipeline is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("stalled result changed");

   // an empty output register never blocks requests
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with no result waiting");

   // a stalled result stops the request side
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while pipeline held");

   // pad bits of the result stay zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_W-1:2*COORD_WIDTH+1] == '0)
      else $error("result pad bits set");

endmodule

bind capsule_circle_hit_test_core capsule_circle_hit_test_checker #(
   .COORD_WIDTH(COORD_WIDTH)
) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready)
);

`default_nettype wire
